// File: rtl/core/stp_pm_pkg.sv
// Package: types and constants shared by the port protocol migration machine.
package stp_pm_pkg;

    localparam int DELAY_W = 8;
    localparam int FV_W    = 2;

    localparam logic [FV_W-1:0]    FORCE_VERSION_RST = 2'd2;
    localparam logic [DELAY_W-1:0] MIGRATE_TIME_RST  = 8'd3;
    localparam logic [FV_W-1:0]    FV_RSTP_MIN       = 2'd2;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    typedef enum logic [0:0] {
        REG_FORCE_VERSION = 1'b0,
        REG_MIGRATE_TIME  = 1'b1
    } reg_sel_t;

    typedef enum logic [2:0] {
        PM_INIT         = 3'd0,
        PM_SEND_RSTP    = 3'd1,
        PM_SENDING_RSTP = 3'd2,
        PM_SEND_STP     = 3'd3,
        PM_SENDING_STP  = 3'd4
    } pm_mode_t;

    typedef struct packed {
        pm_mode_t           mode;
        logic               init_flag;
        logic               mcheck_flag;
        logic               rstp_tx_flag;
        logic               stp_seen_flag;
        logic               rstp_seen_flag;
        logic [DELAY_W-1:0] delay_timer;
    } pm_state_t;

    typedef struct packed {
        logic tick;
        logic got_rstp_bpdu;
        logic got_stp_bpdu;
        logic set_mcheck;
        logic port_enabled;
        logic begin_req;
    } pm_in_t;

    typedef struct packed {
        logic [FV_W-1:0]    force_version;
        logic [DELAY_W-1:0] migrate_time;
    } pm_cfg_t;

endpackage

// File: rtl/core/stp_port_protocol_migration_fsm_unit.sv
// Top level of the spanning-tree port protocol migration machine.
// Each accepted input word passes the input register, then the result register.
// Throughput: one word per cycle unless m_tready stalls the output, set by the
// single pass of four chained transition hops between the two registers.
// Reset: machine returns to init with initPm set, timer and flags cleared;
// force_version resets to 2 and migrate_time to 3; no word is held.
module stp_port_protocol_migration_fsm_unit
    import stp_pm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // begin_req, port_enabled, set_mcheck, got_stp_bpdu, got_rstp_bpdu, tick
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // state_code[2:0], rstp_tx, init_pending, mcheck_pending, delay_left[7:0]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    pm_cfg_t   cfg;
    pm_in_t    in_data_reg;
    logic      in_valid_reg;
    logic      out_valid_reg;
    pm_state_t out_data_reg;
    pm_state_t result;
    logic      advance;
    logic      in_take;

    stp_pm_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_take || (in_valid_reg && !advance);
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg.begin_req     <= s_tdata[0];
            in_data_reg.port_enabled  <= s_tdata[1];
            in_data_reg.set_mcheck    <= s_tdata[2];
            in_data_reg.got_stp_bpdu  <= s_tdata[3];
            in_data_reg.got_rstp_bpdu <= s_tdata[4];
            in_data_reg.tick          <= s_tdata[5];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    stp_pm_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_data_reg.delay_timer,
                       out_data_reg.mcheck_flag,
                       out_data_reg.init_flag,
                       out_data_reg.rstp_tx_flag,
                       3'(out_data_reg.mode)};

endmodule

// File: rtl/core/stp_pm_cfg.sv
// APB register block holding force_version and migrate_time.
module stp_pm_cfg
    import stp_pm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output pm_cfg_t               cfg
);

    pm_cfg_t  cfg_reg;
    pm_cfg_t  cfg_next;
    reg_sel_t sel;
    logic     wr_en;

    assign pready = 1'b1;
    assign sel    = reg_sel_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (sel)
                REG_FORCE_VERSION: cfg_next.force_version = pwdata[FV_W-1:0];
                REG_MIGRATE_TIME:  cfg_next.migrate_time  = pwdata[DELAY_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.force_version <= FORCE_VERSION_RST;
            cfg_reg.migrate_time  <= MIGRATE_TIME_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_FORCE_VERSION: prdata = {{(APB_DATA_W-FV_W){1'b0}}, cfg_reg.force_version};
            REG_MIGRATE_TIME:  prdata = {{(APB_DATA_W-DELAY_W){1'b0}}, cfg_reg.migrate_time};
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/stp_pm_hop.sv
// One transition of the migration machine with its entry actions.
module stp_pm_hop
    import stp_pm_pkg::*;
(
    input  pm_state_t cur,
    input  logic      enabled,
    input  pm_cfg_t   cfg,
    output pm_state_t nxt
);

    pm_mode_t target;
    logic     take;
    logic     seen;
    logic     rstp_ok;
    logic     timer_zero;

    assign seen       = cur.stp_seen_flag || cur.rstp_seen_flag;
    assign rstp_ok    = cfg.force_version >= FV_RSTP_MIN;
    assign timer_zero = cur.delay_timer == '0;

    // Next state.
    always_comb
    begin
        target = cur.mode;
        take   = 1'b0;
        if (!enabled && !cur.init_flag)
        begin
            target = PM_INIT;
            take   = 1'b1;
        end
        else
        begin
            unique case (cur.mode)
                PM_INIT:
                begin
                    if (enabled)
                    begin
                        target = rstp_ok ? PM_SEND_RSTP : PM_SEND_STP;
                        take   = 1'b1;
                    end
                end
                PM_SEND_RSTP:
                begin
                    target = PM_SENDING_RSTP;
                    take   = 1'b1;
                end
                PM_SENDING_RSTP:
                begin
                    priority if (cur.mcheck_flag)
                    begin
                        target = PM_SEND_RSTP;
                        take   = 1'b1;
                    end
                    else if (!timer_zero && seen)
                    begin
                        target = PM_SENDING_RSTP;
                        take   = 1'b1;
                    end
                    else if (timer_zero && cur.stp_seen_flag)
                    begin
                        target = PM_SEND_STP;
                        take   = 1'b1;
                    end
                    else if (!rstp_ok)
                    begin
                        target = PM_SEND_STP;
                        take   = 1'b1;
                    end
                    else
                    begin
                        take = 1'b0;
                    end
                end
                PM_SEND_STP:
                begin
                    target = PM_SENDING_STP;
                    take   = 1'b1;
                end
                PM_SENDING_STP:
                begin
                    priority if (cur.mcheck_flag)
                    begin
                        target = PM_SEND_RSTP;
                        take   = 1'b1;
                    end
                    else if (!timer_zero && seen)
                    begin
                        target = PM_SENDING_STP;
                        take   = 1'b1;
                    end
                    else if (timer_zero && cur.rstp_seen_flag)
                    begin
                        target = PM_SEND_RSTP;
                        take   = 1'b1;
                    end
                    else
                    begin
                        take = 1'b0;
                    end
                end
                default:
                begin
                    target = PM_INIT;
                    take   = 1'b1;
                end
            endcase
        end
    end

    // Entry actions.
    always_comb
    begin
        nxt = cur;
        if (take)
        begin
            nxt.mode = target;
            unique case (target)
                PM_INIT:
                begin
                    nxt.init_flag   = 1'b1;
                    nxt.mcheck_flag = 1'b0;
                end
                PM_SEND_RSTP:
                begin
                    nxt.delay_timer  = cfg.migrate_time;
                    nxt.mcheck_flag  = 1'b0;
                    nxt.init_flag    = 1'b0;
                    nxt.rstp_tx_flag = 1'b1;
                end
                PM_SEND_STP:
                begin
                    nxt.delay_timer  = cfg.migrate_time;
                    nxt.rstp_tx_flag = 1'b0;
                    nxt.init_flag    = 1'b0;
                end
                default:
                begin
                    nxt.stp_seen_flag  = 1'b0;
                    nxt.rstp_seen_flag = 1'b0;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/stp_pm_core.sv
// Machine state register: flag latch, timer count-down and four chained hops.
module stp_pm_core
    import stp_pm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  pm_in_t    item,
    input  pm_cfg_t   cfg,
    output pm_state_t result
);

    localparam int HOPS = 4;

    pm_state_t state_reg;
    pm_state_t state_next;
    pm_state_t latched;
    pm_state_t chain [HOPS+1];

    // Latch requests, count the timer down.
    always_comb
    begin
        latched = state_reg;
        if (item.set_mcheck)
        begin
            latched.mcheck_flag = 1'b1;
        end
        if (item.got_stp_bpdu)
        begin
            latched.stp_seen_flag = 1'b1;
        end
        if (item.got_rstp_bpdu)
        begin
            latched.rstp_seen_flag = 1'b1;
        end
        if (item.tick && state_reg.delay_timer != '0)
        begin
            latched.delay_timer = state_reg.delay_timer - DELAY_W'(1);
        end
    end

    assign chain[0] = latched;

    for (genvar h = 0; h < HOPS; h++)
    begin : g_hop
        stp_pm_hop u_hop
        (
            .cur     (chain[h]),
            .enabled (item.port_enabled),
            .cfg     (cfg),
            .nxt     (chain[h+1])
        );
    end

    always_comb
    begin
        state_next = chain[HOPS];
        if (item.begin_req)
        begin
            state_next             = latched;
            state_next.mode        = PM_INIT;
            state_next.init_flag   = 1'b1;
            state_next.mcheck_flag = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode           <= PM_INIT;
            state_reg.init_flag      <= 1'b1;
            state_reg.mcheck_flag    <= 1'b0;
            state_reg.rstp_tx_flag   <= 1'b0;
            state_reg.stp_seen_flag  <= 1'b0;
            state_reg.rstp_seen_flag <= 1'b0;
            state_reg.delay_timer    <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign result = state_next;

endmodule
